[rtl/stack_machine_execute_unit_macros.svh]
// Assertion macros used by the RTL of the stack machine execute unit.
// Each macro takes a label, the clock, the active-low reset, a condition
// and a consequence.
`ifndef STACK_MACHINE_EXECUTE_UNIT_MACROS_SVH
`define STACK_MACHINE_EXECUTE_UNIT_MACROS_SVH

`ifndef NO_ASSERTIONS

// The consequence holds in the same cycle as the condition.
`define SMEU_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// The consequence holds in the cycle after the condition.
`define SMEU_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define SMEU_ASSERT_SAME(lbl, clk, rst_n, ante, cons)
`define SMEU_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

[rtl/smeu_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package smeu_pkg;

    localparam int CMD_W     = 5;
    localparam int DATA_W    = 32;
    localparam int NLOC_W    = 6;
    localparam int OUT_PC_W  = 16;
    localparam int ERR_W     = 3;

    typedef enum logic [CMD_W-1:0] {
        OP_POP      = 5'd0,
        OP_IADD     = 5'd1,
        OP_ISUB     = 5'd2,
        OP_MUL      = 5'd3,
        OP_IDIV     = 5'd4,
        OP_IMOD     = 5'd5,
        OP_CONST    = 5'd6,
        OP_ILT      = 5'd7,
        OP_IEQ      = 5'd8,
        OP_MARK     = 5'd9,
        OP_FUNC     = 5'd10,
        OP_BR       = 5'd11,
        OP_BRT      = 5'd12,
        OP_LOAD     = 5'd13,
        OP_FRAME_ST = 5'd14,
        OP_EMIT     = 5'd15,
        OP_CALL     = 5'd16,
        OP_RET      = 5'd17,
        OP_HALT     = 5'd18
    } t_opcode;

    typedef enum logic [ERR_W-1:0] {
        ERR_NONE      = 3'd0,
        ERR_OVERFLOW  = 3'd1,
        ERR_UNDERFLOW = 3'd2,
        ERR_DIV_ZERO  = 3'd3,
        ERR_BAD_FRAME = 3'd4,
        ERR_BAD_ADDR  = 3'd5,
        ERR_OPCODE    = 3'd6
    } t_err;

    typedef enum logic [4:0] {
        S_IDLE,
        S_DEC,
        S_BIN_X,
        S_BIN_Y,
        S_BIN_EX,
        S_DIV,
        S_DIV_FIN,
        S_FUNC_Z,
        S_FUNC_B,
        S_FUNC_F,
        S_BRT,
        S_PRINT,
        S_FR_NL,
        S_FR_NA,
        S_FR_CHK,
        S_LD_W,
        S_ST_W,
        S_RET_FP,
        S_RET_NL,
        S_RET_RA,
        S_RET_W,
        S_FIN
    } t_state;

endpackage

`default_nettype wire

[rtl/smeu_in_if.sv]
`timescale 1ns / 1ps
`default_nettype none

interface smeu_in_if
    import smeu_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic [CMD_W-1:0]         cmd;
    logic signed [DATA_W-1:0] operand_a;
    logic [NLOC_W-1:0]        operand_b;

    modport source (output valid, cmd, operand_a, operand_b, input ready);
    modport sink   (input valid, cmd, operand_a, operand_b, output ready);
endinterface

`default_nettype wire

[rtl/smeu_out_if.sv]
`timescale 1ns / 1ps
`default_nettype none

interface smeu_out_if
    import smeu_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic [OUT_PC_W-1:0]      next_pc;
    logic                     print_valid;
    logic signed [DATA_W-1:0] print_value;
    logic                     halted;
    logic [ERR_W-1:0]         error_code;

    modport source (output valid, next_pc, print_valid, print_value, halted, error_code,
                    input ready);
    modport sink   (input valid, next_pc, print_valid, print_value, halted, error_code,
                    output ready);
endinterface

`default_nettype wire

[rtl/stack_machine_execute_unit.sv]
`timescale 1ns / 1ps
`default_nettype none
`include "stack_machine_execute_unit_macros.svh"

// Channel   Dir  Port    Payload
// -------   ---  ------  ------------------------------------------------------
// command   in   i_in    cmd, operand_a, operand_b
// result    out  o_out   next_pc, print_valid, print_value, halted, error_code
//
// Each instruction has an accept step (S_IDLE), a decode step (S_DEC) and a finish
// step (S_FIN), plus the states its stack memory reads, checks and write-back need:
// POP, LABEL, BR, ICONST, CALL and HALT go from decode straight to finish, FUNC
// writes one zero per local before its frame words, and IDIV and IMOD run the
// divider, which retires one quotient bit per cycle.
// Reset (synchronous, active low) clears sp, fp, pc, the stop flag, the latched
// error code and the output valid flag; the stack memory itself is not cleared.
// A new item is taken while a finished result still waits in the output
// register; the finish step stalls until that register drains.

module stack_machine_execute_unit
    import smeu_pkg::*;
#(
    parameter int STACK_DEPTH    = 64,
    parameter int CODE_ADDR_BITS = 16
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    smeu_in_if.sink    i_in,
    smeu_out_if.source o_out
);

    localparam int AW  = $clog2(STACK_DEPTH);
    localparam int SPW = $clog2(STACK_DEPTH + 1);
    localparam int PCW = CODE_ADDR_BITS;
    // Wide signed width for frame arithmetic on 32-bit stored values.
    localparam int WW  = 36;

    // Stack memory: one write port, one registered read port.
    logic [DATA_W-1:0] r_mem [STACK_DEPTH];
    logic [DATA_W-1:0] r_rd;
    logic              m_we;
    logic [AW-1:0]     m_waddr;
    logic [AW-1:0]     m_raddr;
    logic [DATA_W-1:0] m_wdata;

    t_state r_state, n_state;

    // Architectural state.
    logic [SPW-1:0] r_sp, n_sp;
    logic [SPW-1:0] r_fp, n_fp;
    logic [PCW-1:0] r_pc, n_pc;
    logic           r_stopped, n_stopped;
    t_err           r_elatch, n_elatch;

    // Per-instruction working registers.
    t_opcode                  r_cmd;
    logic signed [DATA_W-1:0] r_a;
    logic [NLOC_W-1:0]        r_b;
    logic signed [DATA_W-1:0] r_x, n_x;
    logic signed [DATA_W-1:0] r_y, n_y;
    logic signed [WW-1:0]     r_sum, n_sum;
    logic [AW-1:0]            r_pos, n_pos;
    logic [NLOC_W-1:0]        r_cnt, n_cnt;
    logic [DATA_W-1:0]        r_dv, n_dv;
    logic [DATA_W-1:0]        r_dq, n_dq;
    logic [DATA_W-1:0]        r_dr, n_dr;
    logic [PCW-1:0]           r_next, n_next;
    logic                     r_pv, n_pv;
    logic [DATA_W-1:0]        r_pval, n_pval;
    t_err                     r_err, n_err;
    logic                     r_halt, n_halt;

    // Output register.
    logic                r_ov, n_ov;
    logic [OUT_PC_W-1:0] r_o_pc, n_o_pc;
    logic                r_o_pv, n_o_pv;
    logic [DATA_W-1:0]   r_o_pval, n_o_pval;
    logic                r_o_halt, n_o_halt;
    t_err                r_o_err, n_o_err;

    // Helpers.
    logic [SPW-1:0]       w_sp_m1, w_sp_m2, w_sp_m3, w_sp_p1, w_fp_m1, w_fp_m2;
    logic [PCW-1:0]       w_pc1, w_pc2, w_pc3;
    logic                 w_a_ok, w_rd_ok;
    logic signed [WW-1:0] w_sp_s, w_fp_s, w_idx_s, w_rd_s, w_x_s, w_y_s;
    logic signed [WW-1:0] w_pos_full, w_nsp;
    logic [WW-1:0]        w_func_top;
    logic                 w_frame_bad;
    logic [DATA_W-1:0]    w_mul, w_ux, w_uy, w_quo, w_rem;
    logic [DATA_W:0]      w_trial;
    logic                 w_ge;

    assign w_sp_m1 = r_sp - SPW'(1);
    assign w_sp_m2 = r_sp - SPW'(2);
    assign w_sp_m3 = r_sp - SPW'(3);
    assign w_sp_p1 = r_sp + SPW'(1);
    assign w_fp_m1 = r_fp - SPW'(1);
    assign w_fp_m2 = r_fp - SPW'(2);
    assign w_pc1   = r_pc + PCW'(1);
    assign w_pc2   = r_pc + PCW'(2);
    assign w_pc3   = r_pc + PCW'(3);

    assign w_a_ok  = !r_a[DATA_W-1] && ((({1'b0, r_a}) >> CODE_ADDR_BITS) == '0);
    assign w_rd_ok = !r_rd[DATA_W-1] && ((({1'b0, r_rd}) >> CODE_ADDR_BITS) == '0);

    assign w_sp_s  = signed'(WW'(r_sp));
    assign w_fp_s  = signed'(WW'(r_fp));
    assign w_idx_s = WW'(r_a);
    assign w_rd_s  = WW'(signed'(r_rd));
    assign w_x_s   = WW'(r_x);
    assign w_y_s   = WW'(r_y);

    assign w_func_top  = WW'(r_sp) + WW'(r_b) + WW'(3);
    // A frame is bad when the index is negative or the register pair does not describe a frame that fits.
    assign w_frame_bad = r_a[DATA_W-1] || (r_fp < SPW'(3)) || (r_fp > r_sp);

    // Slot position: fp - 3 - (nlocals + nargs) + index, skipping the return slot.
    assign w_pos_full = w_fp_s - WW'(3) - r_sum + w_idx_s
                        + ((w_idx_s >= w_y_s) ? WW'(1) : WW'(0));
    assign w_nsp      = w_sp_s - WW'(5) - w_rd_s;

    assign w_mul   = r_y * r_x;
    assign w_ux    = r_x[DATA_W-1] ? DATA_W'(-r_x) : DATA_W'(r_x);
    assign w_uy    = r_y[DATA_W-1] ? DATA_W'(-r_y) : DATA_W'(r_y);
    assign w_trial = {r_dr, r_dq[DATA_W-1]};
    assign w_ge    = w_trial >= {1'b0, r_dv};
    assign w_quo   = (r_x[DATA_W-1] ^ r_y[DATA_W-1]) ? DATA_W'(-r_dq) : r_dq;
    assign w_rem   = r_y[DATA_W-1] ? DATA_W'(-r_dr) : r_dr;

    assign i_in.ready        = (r_state == S_IDLE);
    assign o_out.valid       = r_ov;
    assign o_out.next_pc     = r_o_pc;
    assign o_out.print_valid = r_o_pv;
    assign o_out.print_value = signed'(r_o_pval);
    assign o_out.halted      = r_o_halt;
    assign o_out.error_code  = r_o_err;

    always_ff @(posedge i_clk) begin
        if (m_we) begin
            r_mem[m_waddr] <= m_wdata;
        end
        r_rd <= r_mem[m_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sp      <= '0;
            r_fp      <= '0;
            r_pc      <= '0;
            r_stopped <= 1'b0;
            r_elatch  <= ERR_NONE;
            r_ov      <= 1'b0;
        end else begin
            r_sp      <= n_sp;
            r_fp      <= n_fp;
            r_pc      <= n_pc;
            r_stopped <= n_stopped;
            r_elatch  <= n_elatch;
            r_ov      <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_cmd <= t_opcode'(i_in.cmd);
            r_a   <= i_in.operand_a;
            r_b   <= i_in.operand_b;
        end
        r_x      <= n_x;
        r_y      <= n_y;
        r_sum    <= n_sum;
        r_pos    <= n_pos;
        r_cnt    <= n_cnt;
        r_dv     <= n_dv;
        r_dq     <= n_dq;
        r_dr     <= n_dr;
        r_next   <= n_next;
        r_pv     <= n_pv;
        r_pval   <= n_pval;
        r_err    <= n_err;
        r_halt   <= n_halt;
        r_o_pc   <= n_o_pc;
        r_o_pv   <= n_o_pv;
        r_o_pval <= n_o_pval;
        r_o_halt <= n_o_halt;
        r_o_err  <= n_o_err;
    end

    always_comb begin
        n_state   = r_state;
        n_sp      = r_sp;
        n_fp      = r_fp;
        n_pc      = r_pc;
        n_stopped = r_stopped;
        n_elatch  = r_elatch;
        n_x       = r_x;
        n_y       = r_y;
        n_sum     = r_sum;
        n_pos     = r_pos;
        n_cnt     = r_cnt;
        n_dv      = r_dv;
        n_dq      = r_dq;
        n_dr      = r_dr;
        n_next    = r_next;
        n_pv      = r_pv;
        n_pval    = r_pval;
        n_err     = r_err;
        n_halt    = r_halt;
        n_ov      = r_ov && !o_out.ready;
        n_o_pc    = r_o_pc;
        n_o_pv    = r_o_pv;
        n_o_pval  = r_o_pval;
        n_o_halt  = r_o_halt;
        n_o_err   = r_o_err;
        m_we      = 1'b0;
        m_waddr   = r_sp[AW-1:0];
        m_wdata   = '0;
        m_raddr   = w_sp_m1[AW-1:0];

        unique case (r_state)
            S_IDLE: begin
                if (i_in.valid) begin
                    n_state = S_DEC;
                end
            end

            S_DEC: begin
                n_err   = ERR_NONE;
                n_pv    = 1'b0;
                n_pval  = '0;
                n_halt  = 1'b0;
                n_next  = w_pc1;
                n_state = S_FIN;
                if (!r_stopped) begin
                    unique case (r_cmd)
                        OP_POP: begin
                            if (r_sp == '0) begin
                                n_err = ERR_UNDERFLOW;
                            end else begin
                                n_sp = w_sp_m1;
                            end
                        end
                        OP_IADD, OP_ISUB, OP_MUL, OP_IDIV, OP_IMOD, OP_ILT, OP_IEQ: begin
                            if (r_sp < SPW'(2)) begin
                                n_err = ERR_UNDERFLOW;
                            end else begin
                                m_raddr = w_sp_m1[AW-1:0];
                                n_state = S_BIN_X;
                            end
                        end
                        OP_CONST: begin
                            n_next = w_pc2;
                            if (r_sp >= SPW'(STACK_DEPTH)) begin
                                n_err = ERR_OVERFLOW;
                            end else begin
                                m_we    = 1'b1;
                                m_wdata = r_a;
                                n_sp    = w_sp_p1;
                            end
                        end
                        OP_MARK: begin
                        end
                        OP_FUNC: begin
                            n_next = w_pc3;
                            if (w_func_top > WW'(STACK_DEPTH)) begin
                                n_err = ERR_OVERFLOW;
                            end else begin
                                n_cnt   = r_b;
                                n_state = S_FUNC_Z;
                            end
                        end
                        OP_BR: begin
                            if (!w_a_ok) begin
                                n_err = ERR_BAD_ADDR;
                            end else begin
                                n_next = PCW'(r_a);
                            end
                        end
                        OP_BRT: begin
                            n_next = w_pc2;
                            if (r_sp == '0) begin
                                n_err = ERR_UNDERFLOW;
                            end else begin
                                m_raddr = w_sp_m1[AW-1:0];
                                n_state = S_BRT;
                            end
                        end
                        OP_LOAD: begin
                            n_next = w_pc2;
                            if (r_sp >= SPW'(STACK_DEPTH)) begin
                                n_err = ERR_OVERFLOW;
                            end else if (w_frame_bad) begin
                                n_err = ERR_BAD_FRAME;
                            end else begin
                                m_raddr = w_fp_m1[AW-1:0];
                                n_state = S_FR_NL;
                            end
                        end
                        OP_FRAME_ST: begin
                            n_next = w_pc2;
                            if (r_sp == '0) begin
                                n_err = ERR_UNDERFLOW;
                            end else if (w_frame_bad) begin
                                n_err = ERR_BAD_FRAME;
                            end else begin
                                m_raddr = w_fp_m1[AW-1:0];
                                n_state = S_FR_NL;
                            end
                        end
                        OP_EMIT: begin
                            if (r_sp == '0) begin
                                n_err = ERR_UNDERFLOW;
                            end else begin
                                m_raddr = w_sp_m1[AW-1:0];
                                n_state = S_PRINT;
                            end
                        end
                        OP_CALL: begin
                            n_next = w_pc2;
                            if (r_sp >= SPW'(STACK_DEPTH)) begin
                                n_err = ERR_OVERFLOW;
                            end else if (!w_a_ok) begin
                                n_err = ERR_BAD_ADDR;
                            end else begin
                                m_we    = 1'b1;
                                m_wdata = DATA_W'(w_pc2);
                                n_sp    = w_sp_p1;
                                n_next  = PCW'(r_a);
                            end
                        end
                        OP_RET: begin
                            if (r_sp < SPW'(4)) begin
                                n_err = ERR_UNDERFLOW;
                            end else begin
                                m_raddr = w_sp_m2[AW-1:0];
                                n_state = S_RET_FP;
                            end
                        end
                        OP_HALT: begin
                            n_halt = 1'b1;
                        end
                        default: begin
                            n_err = ERR_OPCODE;
                        end
                    endcase
                end
            end

            S_BIN_X: begin
                n_x     = signed'(r_rd);
                m_raddr = w_sp_m2[AW-1:0];
                n_state = S_BIN_Y;
            end

            S_BIN_Y: begin
                n_y     = signed'(r_rd);
                n_state = S_BIN_EX;
            end

            S_BIN_EX: begin
                m_waddr = w_sp_m2[AW-1:0];
                n_state = S_FIN;
                unique case (r_cmd)
                    OP_IADD: begin
                        m_we    = 1'b1;
                        m_wdata = r_y + r_x;
                        n_sp    = w_sp_m1;
                    end
                    OP_ISUB: begin
                        m_we    = 1'b1;
                        m_wdata = r_y - r_x;
                        n_sp    = w_sp_m1;
                    end
                    OP_MUL: begin
                        m_we    = 1'b1;
                        m_wdata = w_mul;
                        n_sp    = w_sp_m1;
                    end
                    OP_ILT: begin
                        m_we    = 1'b1;
                        m_wdata = (r_y < r_x) ? DATA_W'(1) : DATA_W'(0);
                        n_sp    = w_sp_m1;
                    end
                    OP_IEQ: begin
                        m_we    = 1'b1;
                        m_wdata = (r_y == r_x) ? DATA_W'(1) : DATA_W'(0);
                        n_sp    = w_sp_m1;
                    end
                    default: begin
                        // Divide and modulo run through the bit-serial divider.
                        if (r_x == '0) begin
                            n_err = ERR_DIV_ZERO;
                        end else begin
                            n_dv    = w_ux;
                            n_dq    = w_uy;
                            n_dr    = '0;
                            n_cnt   = NLOC_W'(DATA_W);
                            n_state = S_DIV;
                        end
                    end
                endcase
            end

            S_DIV: begin
                n_dr = w_ge ? DATA_W'(w_trial - {1'b0, r_dv}) : w_trial[DATA_W-1:0];
                n_dq = {r_dq[DATA_W-2:0], w_ge};
                n_cnt = r_cnt - NLOC_W'(1);
                if (r_cnt == NLOC_W'(1)) begin
                    n_state = S_DIV_FIN;
                end
            end

            S_DIV_FIN: begin
                m_we    = 1'b1;
                m_waddr = w_sp_m2[AW-1:0];
                m_wdata = (r_cmd == OP_IDIV) ? w_quo : w_rem;
                n_sp    = w_sp_m1;
                n_state = S_FIN;
            end

            S_FUNC_Z: begin
                m_we = 1'b1;
                n_sp = w_sp_p1;
                if (r_cnt != '0) begin
                    m_wdata = '0;
                    n_cnt   = r_cnt - NLOC_W'(1);
                end else begin
                    m_wdata = r_a;
                    n_state = S_FUNC_B;
                end
            end

            S_FUNC_B: begin
                m_we    = 1'b1;
                m_wdata = DATA_W'(r_b);
                n_sp    = w_sp_p1;
                n_state = S_FUNC_F;
            end

            S_FUNC_F: begin
                m_we    = 1'b1;
                m_wdata = DATA_W'(r_fp);
                n_fp    = r_sp;
                n_sp    = w_sp_p1;
                n_state = S_FIN;
            end

            S_BRT: begin
                n_state = S_FIN;
                if (r_rd != '0) begin
                    if (!w_a_ok) begin
                        n_err = ERR_BAD_ADDR;
                    end else begin
                        n_next = PCW'(r_a);
                    end
                end
            end

            S_PRINT: begin
                n_pv    = 1'b1;
                n_pval  = r_rd;
                n_sp    = w_sp_m1;
                n_state = S_FIN;
            end

            S_FR_NL: begin
                n_x     = signed'(r_rd);
                m_raddr = w_fp_m2[AW-1:0];
                n_state = S_FR_NA;
            end

            S_FR_NA: begin
                n_y     = signed'(r_rd);
                n_sum   = w_x_s + w_rd_s;
                n_state = S_FR_CHK;
            end

            S_FR_CHK: begin
                if (r_x[DATA_W-1] || r_y[DATA_W-1] || (w_fp_s < (r_sum + WW'(3)))
                        || (w_idx_s >= r_sum)) begin
                    n_err   = ERR_BAD_FRAME;
                    n_state = S_FIN;
                end else if (r_cmd == OP_LOAD) begin
                    m_raddr = w_pos_full[AW-1:0];
                    n_state = S_LD_W;
                end else begin
                    n_pos   = w_pos_full[AW-1:0];
                    m_raddr = w_sp_m1[AW-1:0];
                    n_state = S_ST_W;
                end
            end

            S_LD_W: begin
                m_we    = 1'b1;
                m_wdata = r_rd;
                n_sp    = w_sp_p1;
                n_state = S_FIN;
            end

            S_ST_W: begin
                m_we    = 1'b1;
                m_waddr = r_pos;
                m_wdata = r_rd;
                n_sp    = w_sp_m1;
                n_state = S_FIN;
            end

            S_RET_FP: begin
                n_x     = signed'(r_rd);
                m_raddr = w_sp_m3[AW-1:0];
                n_state = S_RET_NL;
            end

            S_RET_NL: begin
                n_y = signed'(r_rd);
                if (r_rd[DATA_W-1]) begin
                    n_err   = ERR_BAD_FRAME;
                    n_state = S_FIN;
                end else if (w_sp_s < (WW'(5) + w_rd_s)) begin
                    n_err   = ERR_UNDERFLOW;
                    n_state = S_FIN;
                end else begin
                    n_pos   = w_nsp[AW-1:0];
                    m_raddr = w_nsp[AW-1:0];
                    n_state = S_RET_RA;
                end
            end

            S_RET_RA: begin
                if (r_x[DATA_W-1] || (w_x_s > signed'(WW'(r_pos)))) begin
                    n_err   = ERR_BAD_FRAME;
                    n_state = S_FIN;
                end else if (!w_rd_ok) begin
                    n_err   = ERR_BAD_ADDR;
                    n_state = S_FIN;
                end else begin
                    n_next  = PCW'(r_rd);
                    m_raddr = w_sp_m1[AW-1:0];
                    n_state = S_RET_W;
                end
            end

            S_RET_W: begin
                m_we    = 1'b1;
                m_waddr = r_pos;
                m_wdata = r_rd;
                n_sp    = SPW'(r_pos) + SPW'(1);
                n_fp    = r_x[SPW-1:0];
                n_state = S_FIN;
            end

            S_FIN: begin
                if (!r_ov || o_out.ready) begin
                    n_ov     = 1'b1;
                    n_state  = S_IDLE;
                    n_o_pv   = 1'b0;
                    n_o_pval = '0;
                    n_o_halt = 1'b1;
                    n_o_pc   = OUT_PC_W'(r_pc);
                    if (r_stopped) begin
                        n_o_err = r_elatch;
                    end else if (r_err != ERR_NONE) begin
                        n_stopped = 1'b1;
                        n_elatch  = r_err;
                        n_o_err   = r_err;
                    end else begin
                        n_pc      = r_next;
                        n_stopped = r_halt;
                        n_o_pc    = OUT_PC_W'(r_next);
                        n_o_pv    = r_pv;
                        n_o_pval  = r_pval;
                        n_o_halt  = r_halt;
                        n_o_err   = ERR_NONE;
                    end
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // The stack pointer never passes the stack depth.
    `SMEU_ASSERT_SAME(a_sp_range, i_clk, i_rst_n, 1'b1, r_sp <= SPW'(STACK_DEPTH))
    // Once stopped, the block stays stopped until reset.
    `SMEU_ASSERT_NEXT(a_stop_sticky, i_clk, i_rst_n, r_stopped, r_stopped)
    // Any reported error comes with the halted flag.
    `SMEU_ASSERT_SAME(a_err_halts, i_clk, i_rst_n, r_ov && (r_o_err != ERR_NONE), r_o_halt)
    // The divider never runs on a zero divisor.
    `SMEU_ASSERT_SAME(a_div_nonzero, i_clk, i_rst_n, r_state == S_DIV, r_dv != '0)

endmodule

`default_nettype wire

[tb/tb_stack_machine_execute_unit.sv]
`timescale 1ns / 1ps

module tb_stack_machine_execute_unit;
    import smeu_pkg::*;

    localparam int DEPTH      = 64;
    localparam int IDLE_LIMIT = 4000;

    typedef struct {
        logic [CMD_W-1:0]         cmd;
        logic signed [DATA_W-1:0] a;
        logic [NLOC_W-1:0]        b;
    } t_instr;

    typedef struct {
        logic [OUT_PC_W-1:0] next_pc;
        logic                print_valid;
        logic [DATA_W-1:0]   print_value;
        logic                halted;
        logic [ERR_W-1:0]    error_code;
    } t_outcome;

    typedef struct {
        t_instr   ins;
        t_outcome res;
    } t_job;

    // Architectural state of the machine as the checker sees it.
    typedef struct {
        logic [DATA_W-1:0]   stk [DEPTH];
        int                  sp;
        int                  fp;
        logic [OUT_PC_W-1:0] pc;
        bit                  stopped;
        t_err                latch;
    } t_machine;

    logic clk;
    logic rst_n;

    smeu_in_if  in_if ();
    smeu_out_if out_if ();

    stack_machine_execute_unit u_dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    t_machine gen_m;
    t_job     pending_jobs [$];
    t_outcome expected_outcomes [$];
    t_job     cur_job;
    bit       drv_busy;
    bit       drv_taken;
    bit       calm;
    int       in_gap;
    int       out_gap;
    int       idle_cycles;
    int       fail_count;
    int       n_items;
    int       n_results;
    int       n_prints;
    int       n_returns;
    int       n_calls;

    // Resolves a frame slot index to a stack position; returns 0 on a bad frame.
    function automatic bit frame_pos(input t_machine m, input longint idx, input int sp,
                                     output int pos);
        longint nl;
        longint na;
        pos = 0;
        if (idx < 0 || m.fp < 3 || m.fp > sp) return 1'b0;
        nl = longint'($signed(m.stk[m.fp - 1]));
        na = longint'($signed(m.stk[m.fp - 2]));
        if (nl < 0 || na < 0 || longint'(m.fp) < 3 + nl + na || idx >= nl + na) return 1'b0;
        pos = int'(longint'(m.fp) - 3 - nl - na + idx + ((idx >= na) ? 1 : 0));
        return 1'b1;
    endfunction

    function automatic bit code_addr_ok(input longint t);
        return t >= 0 && t <= 65535;
    endfunction

    // Executes one instruction on the machine state and returns the result item.
    function automatic t_outcome execute(ref t_machine m, input t_instr ins);
        t_outcome            r;
        logic [OUT_PC_W-1:0] nxt;
        longint              sa;
        longint              nfp;
        longint              nl;
        longint              nsp;
        longint              ra;
        logic [DATA_W-1:0]   x;
        logic [DATA_W-1:0]   y;
        logic [DATA_W-1:0]   v;
        int                  sp;
        int                  pos;
        t_err                err;
        r.print_valid = 1'b0;
        r.print_value = '0;
        if (m.stopped) begin
            r.next_pc    = m.pc;
            r.halted     = 1'b1;
            r.error_code = m.latch;
            return r;
        end
        sa  = longint'(ins.a);
        nxt = m.pc + 16'd1;
        sp  = m.sp;
        err = ERR_NONE;
        case (ins.cmd)
            OP_POP: begin
                if (sp < 1) err = ERR_UNDERFLOW;
                else sp--;
            end
            OP_IADD, OP_ISUB, OP_MUL, OP_IDIV, OP_IMOD, OP_ILT, OP_IEQ: begin
                if (sp < 2) begin
                    err = ERR_UNDERFLOW;
                end else begin
                    x = m.stk[sp - 1];
                    y = m.stk[sp - 2];
                    v = '0;
                    case (ins.cmd)
                        OP_IADD:  v = y + x;
                        OP_ISUB:  v = y - x;
                        OP_MUL:   v = y * x;
                        OP_ILT:   v = ($signed(y) < $signed(x)) ? 32'd1 : 32'd0;
                        OP_IEQ:   v = (y == x) ? 32'd1 : 32'd0;
                        default: begin
                            // The minimum value over -1 wraps; its remainder is zero.
                            if (x == '0) err = ERR_DIV_ZERO;
                            else if (y == 32'h8000_0000 && x == 32'hFFFF_FFFF)
                                v = (ins.cmd == OP_IDIV) ? y : '0;
                            else if (ins.cmd == OP_IDIV) v = $signed(y) / $signed(x);
                            else v = $signed(y) % $signed(x);
                        end
                    endcase
                    if (err == ERR_NONE) begin
                        m.stk[sp - 2] = v;
                        sp--;
                    end
                end
            end
            OP_CONST: begin
                nxt = m.pc + 16'd2;
                if (sp >= DEPTH) err = ERR_OVERFLOW;
                else begin
                    m.stk[sp] = ins.a;
                    sp++;
                end
            end
            OP_MARK: ;
            OP_FUNC: begin
                nxt = m.pc + 16'd3;
                if (sp + int'(ins.b) + 3 > DEPTH) begin
                    err = ERR_OVERFLOW;
                end else begin
                    for (int i = 0; i < int'(ins.b); i++) begin
                        m.stk[sp] = '0;
                        sp++;
                    end
                    m.stk[sp]   = ins.a;
                    sp++;
                    m.stk[sp]   = {26'd0, ins.b};
                    sp++;
                    m.stk[sp]   = m.fp;
                    m.fp        = sp;
                    sp++;
                end
            end
            OP_BR: begin
                if (!code_addr_ok(sa)) err = ERR_BAD_ADDR;
                else nxt = ins.a[15:0];
            end
            OP_BRT: begin
                nxt = m.pc + 16'd2;
                if (sp < 1) err = ERR_UNDERFLOW;
                else if (m.stk[sp - 1] != '0) begin
                    if (!code_addr_ok(sa)) err = ERR_BAD_ADDR;
                    else nxt = ins.a[15:0];
                end
            end
            OP_LOAD: begin
                nxt = m.pc + 16'd2;
                if (sp >= DEPTH) err = ERR_OVERFLOW;
                else if (!frame_pos(m, sa, sp, pos)) err = ERR_BAD_FRAME;
                else begin
                    m.stk[sp] = m.stk[pos];
                    sp++;
                end
            end
            OP_FRAME_ST: begin
                nxt = m.pc + 16'd2;
                if (sp < 1) err = ERR_UNDERFLOW;
                else if (!frame_pos(m, sa, sp, pos)) err = ERR_BAD_FRAME;
                else begin
                    m.stk[pos] = m.stk[sp - 1];
                    sp--;
                end
            end
            OP_EMIT: begin
                if (sp < 1) err = ERR_UNDERFLOW;
                else begin
                    sp--;
                    r.print_valid = 1'b1;
                    r.print_value = m.stk[sp];
                end
            end
            OP_CALL: begin
                nxt = m.pc + 16'd2;
                if (sp >= DEPTH) err = ERR_OVERFLOW;
                else if (!code_addr_ok(sa)) err = ERR_BAD_ADDR;
                else begin
                    m.stk[sp] = {16'd0, nxt};
                    sp++;
                    nxt = ins.a[15:0];
                end
            end
            OP_RET: begin
                if (sp < 4) err = ERR_UNDERFLOW;
                else begin
                    nfp = longint'($signed(m.stk[sp - 2]));
                    nl  = longint'($signed(m.stk[sp - 3]));
                    if (nl < 0) err = ERR_BAD_FRAME;
                    else if (longint'(sp) < 5 + nl) err = ERR_UNDERFLOW;
                    else begin
                        nsp = longint'(sp) - 5 - nl;
                        ra  = longint'($signed(m.stk[int'(nsp)]));
                        if (nfp < 0 || nfp > nsp) err = ERR_BAD_FRAME;
                        else if (!code_addr_ok(ra)) err = ERR_BAD_ADDR;
                        else begin
                            m.stk[int'(nsp)] = m.stk[sp - 1];
                            sp   = int'(nsp) + 1;
                            m.fp = int'(nfp);
                            nxt  = ra[15:0];
                        end
                    end
                end
            end
            OP_HALT: m.stopped = 1'b1;
            default: err = ERR_OPCODE;
        endcase
        if (err != ERR_NONE) begin
            m.stopped     = 1'b1;
            m.latch       = err;
            nxt           = m.pc;
            r.print_valid = 1'b0;
            r.print_value = '0;
        end else begin
            m.sp = sp;
        end
        m.pc         = nxt;
        r.next_pc    = nxt;
        r.halted     = m.stopped;
        r.error_code = err;
        return r;
    endfunction

    // Runs the instruction on the generator's copy of the machine and queues it
    // together with the result it must produce.
    task automatic issue(input logic [CMD_W-1:0] cmd, input logic [DATA_W-1:0] a,
                         input logic [NLOC_W-1:0] b);
        t_job j;
        j.ins.cmd = cmd;
        j.ins.a   = a;
        j.ins.b   = b;
        j.res     = execute(gen_m, j.ins);
        if (j.res.print_valid) n_prints++;
        if (cmd == OP_RET && j.res.error_code == ERR_NONE) n_returns++;
        if (cmd == OP_CALL && j.res.error_code == ERR_NONE) n_calls++;
        pending_jobs.push_back(j);
    endtask

    function automatic logic [DATA_W-1:0] rand_word();
        case ($urandom_range(0, 7))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2:       return 32'hFFFF_FFFF;
            3:       return $urandom_range(0, 9);
            4:       return -$urandom_range(1, 9);
            default: return $urandom;
        endcase
    endfunction

    // Proposes a random instruction, leaning toward well-formed call sequences.
    function automatic t_instr propose(input t_machine m, input bit after_call);
        t_instr c;
        int     w;
        int     top;
        c.a   = $urandom;
        c.b   = NLOC_W'($urandom);
        w     = $urandom_range(0, 99);
        if (after_call) begin
            c.cmd = OP_FUNC;
            top   = (m.sp - 1 < 3) ? m.sp - 1 : 3;
            c.a   = $urandom_range(0, (top < 0) ? 0 : top);
            c.b   = ($urandom_range(0, 15) == 0) ? NLOC_W'($urandom_range(0, 40))
                                                 : NLOC_W'($urandom_range(0, 4));
            return c;
        end
        if (m.fp >= 3 && m.sp == m.fp + 2 && w < 60) begin
            c.cmd = OP_RET;
            return c;
        end
        if (m.sp > 40 && w < 50) begin
            c.cmd = (w < 25) ? OP_POP : OP_EMIT;
            return c;
        end
        if (w < 20) begin
            c.cmd = OP_CONST;
            c.a   = rand_word();
        end else if (w < 30) begin
            c.cmd = ($urandom_range(0, 1) == 0) ? OP_LOAD : OP_FRAME_ST;
            c.a   = $urandom_range(0, 6);
        end else if (w < 36) begin
            c.cmd = OP_CALL;
            c.a   = $urandom_range(0, 65535);
        end else if (w < 42) begin
            c.cmd = ($urandom_range(0, 1) == 0) ? OP_BR : OP_BRT;
            c.a   = $urandom_range(0, 65535);
        end else begin
            c.cmd = CMD_W'($urandom_range(0, 17));
        end
        return c;
    endfunction

    // Adds one random instruction that keeps the machine running.
    task automatic issue_random(inout bit after_call);
        t_machine trial;
        t_instr   c;
        t_outcome r;
        bit       found;
        found = 1'b0;
        for (int t = 0; t < 60 && !found; t++) begin
            c     = propose(gen_m, after_call);
            trial = gen_m;
            r     = execute(trial, c);
            if (!r.halted) found = 1'b1;
        end
        if (!found) begin
            c.cmd = (gen_m.sp >= DEPTH) ? OP_POP : OP_CONST;
            c.a   = rand_word();
            c.b   = NLOC_W'($urandom);
        end
        after_call = (c.cmd == OP_CALL);
        issue(c.cmd, c.a, c.b);
    endtask

    // Driver: at negedge, presents queued items and output ready, with random gaps.
    always @(negedge clk) begin
        if (rst_n) begin
            if (drv_busy && !drv_taken) begin
                // The current item is still waiting for the handshake.
            end else begin
                drv_busy  = 1'b0;
                drv_taken = 1'b0;
                if (in_gap > 0) begin
                    in_gap--;
                    in_if.valid <= 1'b0;
                end else if (!calm && $urandom_range(0, 11) == 0) begin
                    in_gap = $urandom_range(0, 7);
                    in_if.valid <= 1'b0;
                end else if (pending_jobs.size() > 0) begin
                    cur_job  = pending_jobs.pop_front();
                    drv_busy = 1'b1;
                    in_if.valid     <= 1'b1;
                    in_if.cmd       <= cur_job.ins.cmd;
                    in_if.operand_a <= cur_job.ins.a;
                    in_if.operand_b <= cur_job.ins.b;
                end else begin
                    in_if.valid <= 1'b0;
                end
            end
            if (out_gap > 0) begin
                out_gap--;
                out_if.ready <= 1'b0;
            end else if (!calm && $urandom_range(0, 9) == 0) begin
                out_gap = $urandom_range(0, 7);
                out_if.ready <= 1'b0;
            end else begin
                out_if.ready <= 1'b1;
            end
        end
    end

    // Monitor: records accepted items and checks results at the rising edge.
    always @(posedge clk) begin
        if (rst_n) begin
            idle_cycles++;
            if (in_if.valid && in_if.ready && drv_busy) begin
                expected_outcomes.push_back(cur_job.res);
                drv_taken   = 1'b1;
                idle_cycles = 0;
                n_items++;
            end
            if (out_if.valid && out_if.ready) begin
                idle_cycles = 0;
                n_results++;
                if (expected_outcomes.size() == 0) begin
                    fail_count++;
                    $display("%0t: unexpected result item next_pc=%0h", $time, out_if.next_pc);
                end else begin
                    t_outcome e;
                    e = expected_outcomes.pop_front();
                    if (out_if.next_pc !== e.next_pc || out_if.print_valid !== e.print_valid ||
                        out_if.print_value !== e.print_value || out_if.halted !== e.halted ||
                        out_if.error_code !== e.error_code) begin
                        fail_count++;
                        $display("%0t: mismatch expected pc=%0h pv=%0b val=%0h halt=%0b err=%0d",
                                 $time, e.next_pc, e.print_valid, e.print_value, e.halted,
                                 e.error_code);
                        $display("%0t:          actual   pc=%0h pv=%0b val=%0h halt=%0b err=%0d",
                                 $time, out_if.next_pc, out_if.print_valid, out_if.print_value,
                                 out_if.halted, out_if.error_code);
                    end
                end
            end
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("%0t: no progress for %0d cycles", $time, IDLE_LIMIT);
                $display("stack_machine_execute_unit verification failed");
                $finish;
            end
        end
    end

    initial begin
        bit   after_call;
        int   kind;
        t_err final_err;
        rst_n           = 1'b0;
        in_if.valid     = 1'b0;
        in_if.cmd       = '0;
        in_if.operand_a = '0;
        in_if.operand_b = '0;
        out_if.ready    = 1'b0;
        drv_busy        = 1'b0;
        drv_taken       = 1'b0;
        calm            = 1'b0;
        in_gap          = 0;
        out_gap         = 0;
        idle_cycles     = 0;
        fail_count      = 0;
        after_call      = 1'b0;
        gen_m.sp        = 0;
        gen_m.fp        = 0;
        gen_m.pc        = '0;
        gen_m.stopped   = 1'b0;
        gen_m.latch     = ERR_NONE;
        foreach (gen_m.stk[i]) gen_m.stk[i] = '0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: wrapping arithmetic, the minimum value over -1, comparisons,
        // a full call with frame access and return, and a code address wrap.
        issue(OP_CONST, 32'h7FFF_FFFF, 6'h3F);
        issue(OP_CONST, 32'd1, '0);
        issue(OP_IADD, 32'hFFFF_FFFF, '0);
        issue(OP_EMIT, '0, '0);
        issue(OP_CONST, 32'h8000_0000, '0);
        issue(OP_CONST, 32'hFFFF_FFFF, '0);
        issue(OP_IDIV, '0, '0);
        issue(OP_CONST, 32'hFFFF_FFFF, '0);
        issue(OP_IMOD, '0, '0);
        issue(OP_CONST, -32'sd7, '0);
        issue(OP_CONST, 32'd2, '0);
        issue(OP_IMOD, '0, '0);
        issue(OP_MUL, '0, '0);
        issue(OP_CONST, -32'sd3, '0);
        issue(OP_ISUB, '0, '0);
        issue(OP_CONST, 32'd5, '0);
        issue(OP_ILT, '0, '0);
        issue(OP_BRT, 32'd100, '0);
        issue(OP_CONST, 32'd0, '0);
        issue(OP_IEQ, '0, '0);
        issue(OP_BRT, 32'd200, '0);
        issue(OP_POP, '0, '0);
        issue(OP_CONST, 32'd11, '0);
        issue(OP_CALL, 32'd300, '0);
        issue(OP_FUNC, 32'd1, 6'd2);
        issue(OP_LOAD, 32'd0, '0);
        issue(OP_FRAME_ST, 32'd1, '0);
        issue(OP_LOAD, 32'd2, '0);
        issue(OP_RET, '0, '0);
        issue(OP_BR, 32'd65535, '0);
        issue(OP_MARK, 32'hFFFF_FFFF, 6'h3F);

        // The sender holds off until every result of the directed part is back.
        while (pending_jobs.size() > 0 || drv_busy || expected_outcomes.size() > 0)
            @(posedge clk);

        for (int n = 0; n < 520; n++) begin
            while (pending_jobs.size() >= 4) @(posedge clk);
            if (n == 440) calm = 1'b1;
            issue_random(after_call);
        end

        // The block stops for good on halt or an error, so the run ends with one
        // of them, chosen at random, followed by items that must be ignored.
        kind = $urandom_range(0, 6);
        case (kind)
            0: issue(OP_HALT, $urandom, NLOC_W'($urandom));
            1: begin
                while (gen_m.sp < DEPTH) issue(OP_CONST, rand_word(), '0);
                issue(OP_CONST, rand_word(), '0);
            end
            2: begin
                while (gen_m.sp > 0) issue(OP_POP, '0, '0);
                issue(OP_POP, '0, '0);
            end
            3: begin
                issue(OP_CONST, rand_word(), '0);
                issue(OP_CONST, 32'd0, '0);
                issue(($urandom_range(0, 1) == 0) ? OP_IDIV : OP_IMOD, '0, '0);
            end
            4: begin
                if (gen_m.sp >= DEPTH) issue(OP_POP, '0, '0);
                issue(OP_LOAD, (gen_m.fp < 3) ? 32'd0 : 32'hFFFF_FFFF, '0);
            end
            5: issue(OP_BR, ($urandom_range(0, 1) == 0) ? 32'hFFFF_FFFF : 32'h0001_0000, '0);
            default: issue(CMD_W'($urandom_range(19, 31)), $urandom, NLOC_W'($urandom));
        endcase
        final_err = gen_m.latch;
        for (int n = 0; n < 6; n++)
            issue(CMD_W'($urandom_range(0, 31)), $urandom, NLOC_W'($urandom));

        while (pending_jobs.size() > 0 || drv_busy || expected_outcomes.size() > 0)
            @(posedge clk);
        repeat (60) @(posedge clk);

        if (expected_outcomes.size() > 0) begin
            fail_count++;
            $display("%0t: %0d expected result items never arrived", $time,
                     expected_outcomes.size());
        end
        $display("Ran %0d instructions, %0d results checked: %0d prints, %0d calls, %0d returns.",
                 n_items, n_results, n_prints, n_calls, n_returns);
        $display("The machine stopped with code %0d and then ignored its input.", final_err);
        if (fail_count == 0) begin
            $display("stack_machine_execute_unit verification clean");
        end else begin
            $display("stack_machine_execute_unit verification failed");
        end
        $finish;
    end

endmodule

[stack_machine_execute_unit.f]
+incdir+rtl
rtl/smeu_pkg.sv
rtl/smeu_in_if.sv
rtl/smeu_out_if.sv
rtl/stack_machine_execute_unit.sv
tb/tb_stack_machine_execute_unit.sv
